FILE: rtl/lifla_pkg.sv
// Shared definitions for the lazily initialized free-list slot allocator.
// Holds pool sizing constants, status codes, the control word type and
// the effective slot count helper. No dependencies.
package lifla_pkg;

	localparam int SLOTS_MAX = 256;
	localparam int CNT_W     = 9;
	localparam int IDX_W     = $clog2(SLOTS_MAX);

	localparam logic [CNT_W-1:0] CNT_SAT   = '1;
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(SLOTS_MAX);

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic accept;    // request word taken this cycle
		logic link_step; // allocate link cycle: link data is back
		logic load_out;  // move the finished result into the output register
	} lifla_cmd_t;

	// Clamp the programmed count to the pool depth.
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
		return (cnt > CNT_W'(SLOTS_MAX)) ? CNT_W'(SLOTS_MAX) : cnt;
	endfunction

endpackage

FILE: rtl/lazy_init_free_list_allocator_core.sv
// Channel     Handshake           Payload
// request     in_valid/in_stall   req_type, slot_index
// result      out_valid/out_stall status, granted_index, free_left
// config      cfg_we              cfg_wdata (slot_count)
//
// An allocate has a link cycle that a free skips: the head's link comes back from the
// registered read port of the link store in the cycle after the request word.
// A result moves from the result register to the output register, so a new
// request word is taken while an earlier result still waits under out_stall.
// Reset (arst_n low) gives 256 slots, all free; no clearing pass is needed.
// Writing cfg_wdata sets the slot count and reinitializes the pool.
module lazy_init_free_list_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lifla_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [lifla_pkg::IDX_W-1:0] slot_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [lifla_pkg::IDX_W-1:0] granted_index,
	output logic [lifla_pkg::CNT_W-1:0] free_left
);

	lifla_pkg::lifla_cmd_t cmd;

	lifla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	lifla_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_type      (req_type),
		.slot_index    (slot_index),
		.status        (status),
		.granted_index (granted_index),
		.free_left     (free_left)
	);

endmodule

FILE: rtl/lifla_ctrl.sv
// Request sequencer for the slot allocator: input/output handshake,
// allocate link cycle and output register occupancy.
// Depends on lifla_pkg.
module lifla_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lifla_pkg::lifla_cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		LINK,
		DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// Output register can take a word this cycle.
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall      = (state_q == LINK) || ((state_q == DONE) && !out_free);
	assign cmd.accept    = in_valid && !in_stall;
	assign cmd.link_step = (state_q == LINK);
	assign cmd.load_out  = (state_q == DONE) && out_free;
	assign out_valid     = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE, DONE: begin
					if (cmd.accept) begin
						state_q <= (req_type == lifla_pkg::REQ_ALLOC) ? LINK : DONE;
					end else if (cmd.load_out) begin
						state_q <= IDLE;
					end
				end
				LINK: begin
					state_q <= DONE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_alloc_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && req_type == lifla_pkg::REQ_ALLOC) |=> ##1 (state_q == DONE))
		else $error("allocate did not finish after its link cycle");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("result load did not raise out_valid");

	a_no_accept_in_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link_step |-> $past(cmd.accept))
		else $error("link cycle without a preceding allocate");

endmodule

FILE: rtl/lifla_dp.sv
// Datapath of the slot allocator: pool registers, link store memory,
// result register and output register. Driven by lifla_ctrl commands.
// Depends on lifla_pkg.
module lifla_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lifla_pkg::lifla_cmd_t         cmd,
	input  logic                          cfg_we,
	input  logic [lifla_pkg::CNT_W-1:0]   cfg_wdata,
	input  logic                          req_type,
	input  logic [lifla_pkg::IDX_W-1:0]   slot_index,
	output logic [1:0]                    status,
	output logic [lifla_pkg::IDX_W-1:0]   granted_index,
	output logic [lifla_pkg::CNT_W-1:0]   free_left
);

	localparam int CW = lifla_pkg::CNT_W;
	localparam int IW = lifla_pkg::IDX_W;

	logic [CW-1:0] link_mem [lifla_pkg::SLOTS_MAX];

	logic [CW-1:0] slot_count_q;
	logic [CW-1:0] head_q;
	logic [CW-1:0] free_cnt_q;
	logic [CW-1:0] init_q;
	logic [CW-1:0] rd_q;
	logic          bypass_q;

	logic [1:0]    res_status_q;
	logic [IW-1:0] res_grant_q;
	logic [CW-1:0] res_left_q;
	logic [1:0]    out_status_q;
	logic [IW-1:0] out_grant_q;
	logic [CW-1:0] out_left_q;

	logic [CW-1:0] n;
	logic [CW-1:0] slot_ext;
	logic          lazy_ok;
	logic          free_in_range;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic [CW-1:0] mem_wd;
	logic [CW-1:0] link_val;
	logic [CW-1:0] cnt_dec;
	logic [CW-1:0] cnt_inc;
	logic          pool_empty;

	assign n             = lifla_pkg::eff_count(slot_count_q);
	assign slot_ext      = {1'b0, slot_index};
	assign lazy_ok       = (init_q < n);
	assign free_in_range = (slot_ext < n);
	assign link_val      = bypass_q ? init_q : rd_q;
	assign cnt_dec       = free_cnt_q - 1'b1;
	assign cnt_inc       = (free_cnt_q < lifla_pkg::CNT_SAT) ? free_cnt_q + 1'b1 : free_cnt_q;
	assign pool_empty    = (free_cnt_q == '0) || (head_q >= n);

	// One write port: lazy link on allocate, push link on free.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = init_q[IW-1:0];
		mem_wd = init_q + 1'b1;
		if (cmd.accept) begin
			if (req_type == lifla_pkg::REQ_ALLOC) begin
				mem_we = lazy_ok;
			end else begin
				mem_we = free_in_range;
				mem_wa = slot_index;
				mem_wd = (free_cnt_q != '0) ? head_q : n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		if (cmd.accept) begin
			rd_q <= link_mem[head_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= lifla_pkg::CNT_RESET;
			head_q       <= '0;
			free_cnt_q   <= lifla_pkg::eff_count(lifla_pkg::CNT_RESET);
			init_q       <= '0;
			bypass_q     <= 1'b0;
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
			head_q       <= '0;
			free_cnt_q   <= lifla_pkg::eff_count(cfg_wdata);
			init_q       <= '0;
		end else if (cmd.accept) begin
			if (req_type == lifla_pkg::REQ_ALLOC) begin
				// a freshly linked head reads back its own new link
				bypass_q <= lazy_ok && (head_q == init_q);
				if (lazy_ok) begin
					init_q <= init_q + 1'b1;
				end
			end else if (free_in_range) begin
				head_q     <= slot_ext;
				free_cnt_q <= cnt_inc;
			end
		end else if (cmd.link_step && !pool_empty) begin
			free_cnt_q <= cnt_dec;
			head_q     <= (cnt_dec != '0) ? link_val : n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && req_type == lifla_pkg::REQ_FREE) begin
			res_grant_q <= '0;
			if (free_in_range) begin
				res_status_q <= lifla_pkg::ST_OK;
				res_left_q   <= cnt_inc;
			end else begin
				res_status_q <= lifla_pkg::ST_RANGE;
				res_left_q   <= free_cnt_q;
			end
		end else if (cmd.link_step) begin
			if (pool_empty) begin
				res_status_q <= lifla_pkg::ST_EMPTY;
				res_grant_q  <= '0;
				res_left_q   <= free_cnt_q;
			end else begin
				res_status_q <= lifla_pkg::ST_OK;
				res_grant_q  <= head_q[IW-1:0];
				res_left_q   <= cnt_dec;
			end
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_grant_q  <= res_grant_q;
			out_left_q   <= res_left_q;
		end
	end

	assign status        = out_status_q;
	assign granted_index = out_grant_q;
	assign free_left     = out_left_q;

	a_init_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		init_q <= n)
		else $error("lazy link count ran past the pool size");

	a_grant_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.link_step && !pool_empty && !cfg_we) |=> (free_cnt_q == $past(cnt_dec)))
		else $error("granted allocate did not consume a slot");

	a_range_keeps_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && req_type == lifla_pkg::REQ_FREE && !free_in_range && !cfg_we)
		|=> $stable(head_q) && $stable(free_cnt_q))
		else $error("rejected free changed the list");

endmodule
